/* hw/rtl/lnis_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnis_pkg
// Shared constants, the query record and the length clamp for the
// longest non-increasing subsequence unit.
// ----------------------------------------------------------------------------
package lnis_pkg;

    // Sizing of the sequence store and of the height compare.
    localparam int MAX_ITEMS   = 1024;
    localparam int HEIGHT_BITS = 16;

    // Port field widths.
    localparam int IN_H_W     = 16;
    localparam int OUT_LEN_W  = 11;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    // Height bits that take part in the compare.
    localparam int HT_W = (HEIGHT_BITS < IN_H_W) ? HEIGHT_BITS : IN_H_W;

    // Internal length width: a run length can reach MAX_ITEMS + 1.
    localparam int LEN_W = $clog2(MAX_ITEMS + 2);

    // Reported lengths saturate at this value.
    localparam int LEN_LIMIT = 2047;
    localparam int CMP_W     = (LEN_W > OUT_LEN_W) ? LEN_W : OUT_LEN_W;

    // One request as it walks down the cell row.
    typedef struct packed {
        logic             valid;
        logic [HT_W-1:0]  height;
        logic             last;
        logic             found;    // an empty cell has been passed
        logic [LEN_W-1:0] longest;  // best stored length with height >= this one
    } t_query;

    function automatic logic [OUT_LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        logic [CMP_W-1:0] wv;
        wv = CMP_W'(v);
        if (wv > CMP_W'(LEN_LIMIT)) begin
            return OUT_LEN_W'(LEN_LIMIT);
        end else begin
            return OUT_LEN_W'(wv);
        end
    endfunction

endpackage

/* hw/rtl/lnis_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnis_cell
// One store slot: holds a height and its run length, scores the passing
// request against them and hands the request on to the next slot.
// ----------------------------------------------------------------------------
module lnis_cell
    import lnis_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_query i_q,
    output t_query o_q
);

    logic             r_valid;
    logic [HT_W-1:0]  r_height;
    logic [LEN_W-1:0] r_len;
    logic             r_q_valid;
    logic [HT_W-1:0]  r_q_height;
    logic             r_q_last;
    logic             r_q_found;
    logic [LEN_W-1:0] r_q_longest;

    logic             hit;
    logic             empty;
    logic             store;
    logic [LEN_W-1:0] n_longest;

    always_comb begin
        empty     = !r_valid;
        hit       = i_q.valid && r_valid && (r_height >= i_q.height);
        n_longest = (hit && (r_len > i_q.longest)) ? r_len : i_q.longest;
        // take the request into the first empty slot it meets
        store     = i_q.valid && empty && !i_q.found && !i_q.last;
    end

    // control: slot occupancy and request valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_q_valid <= 1'b0;
        end else if (i_en) begin
            r_q_valid <= i_q.valid;
            if (i_q.valid && i_q.last) begin
                r_valid <= 1'b0;   // drop the slot behind a closing request
            end else if (store) begin
                r_valid <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (store) begin
                r_height <= i_q.height;
                r_len    <= i_q.longest + LEN_W'(1);
            end
            r_q_height  <= i_q.height;
            r_q_last    <= i_q.last;
            r_q_found   <= i_q.found || empty;
            r_q_longest <= n_longest;
        end
    end

    always_comb begin
        o_q.valid   = r_q_valid;
        o_q.height  = r_q_height;
        o_q.last    = r_q_last;
        o_q.found   = r_q_found;
        o_q.longest = r_q_longest;
    end

endmodule

/* hw/rtl/lnis_tail.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnis_tail
// Output stage: forms the run length, tracks the best length of the
// sequence and holds the result until the sink takes it.
// ----------------------------------------------------------------------------
module lnis_tail
    import lnis_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_query                i_q,
    output logic                  o_valid,
    output logic [OUT_DATA_W-1:0] o_data
);

    logic                  r_valid;
    logic [LEN_W-1:0]      r_best;
    logic [OUT_DATA_W-1:0] r_data;

    logic [LEN_W-1:0] run;
    logic [LEN_W-1:0] n_best;

    always_comb begin
        run    = i_q.longest + LEN_W'(1);
        n_best = (run > r_best) ? run : r_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_best  <= '0;
        end else if (i_en) begin
            r_valid <= i_q.valid;
            if (i_q.valid) begin
                r_best <= i_q.last ? '0 : n_best;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_q.valid) begin
            r_data <= {1'b0, !i_q.found, clamp_len(n_best), clamp_len(run)};
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* hw/rtl/longest_non_increasing_subsequence_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_non_increasing_subsequence_unit
// Scores a stream of heights by the longest non-increasing subsequence
// ending at each one, using a row of store slots that requests walk through.
// ----------------------------------------------------------------------------
//
//  channel | dir | ports                     | contents
//  --------+-----+---------------------------+-------------------------------
//  s       | in  | i_s_tvalid/o_s_tready     | tdata: height; tlast: last
//  m       | out | o_m_tvalid/i_m_tready     | tdata: run_length, best_length,
//          |     |                           |        overflow
//
//  One request enters per cycle while the output is not holding the row;
//  each passes one register per slot of the row, then the output register.
//  All slots of the row advance together whenever the row may move.
//  A result waiting at the output holds the whole row, and input with it.
//  Reset empties all slots and the output register; there is no clear pass.
//
module longest_non_increasing_subsequence_unit
    import lnis_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [15:0] height
    input  logic                  i_s_tlast,   // last
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata    // [10:0] run_length,
                                               // [21:11] best_length,
                                               // [22] overflow, [23] zero
);

    // Row advance: move whenever the output register is free or draining.
    logic   en;
    t_query q [MAX_ITEMS+1];

    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // Build the request at the head of the row; only HT_W height bits count.
    always_comb begin
        q[0].valid   = i_s_tvalid;
        q[0].height  = i_s_tdata[HT_W-1:0];
        q[0].last    = i_s_tlast;
        q[0].found   = 1'b0;
        q[0].longest = '0;
    end

    // Each slot scores the request against its entry, claims it if the
    // slot is the first empty one, and drops its entry behind a last request.
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        lnis_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_q     (q[g]),
            .o_q     (q[g+1])
        );
    end

    // Finish the score, track the running best, hold for the sink.
    lnis_tail u_tail (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_q     (q[MAX_ITEMS]),
        .o_valid (o_m_tvalid),
        .o_data  (o_m_tdata)
    );

`ifndef SYNTHESIS
    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[10:0] != '0))
        else $error("run length of zero on output");

    a_best_covers_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[21:11] >= o_m_tdata[10:0]))
        else $error("best length below run length");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with output register empty");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_m_tdata[23])
        else $error("pad bit set on output");
`endif

endmodule
